// ===== sv/hmh_pkg.sv =====
package hmh_pkg;

  localparam int CAPACITY_DEF  = 256;
  localparam int PRIO_BITS_DEF = 32;
  localparam int ID_BITS       = 8;
  localparam int ID_COUNT      = 256;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_CHANGE = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_DUP    = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;

  // controller -> datapath, one step per cycle
  typedef struct packed {
    logic       latch;
    logic       fail;
    logic [2:0] fail_code;
    logic       ins_start;
    logic       pop_start;
    logic       pop_take;
    logic       locate;
    logic       at_slot;
    logic       up_issue;
    logic       up_move;
    logic       dn_issue;
    logic       dn_move;
    logic       place;
    logic       load_out;
  } hmh_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] act;
    logic       present;
    logic       full;
    logic       empty;
    logic       last_slot;
    logic       grow;
    logic       shrink;
    logic       at_root;
    logic       up_swap;
    logic       no_child;
    logic       dn_swap;
  } hmh_flag_t;

endpackage

// ===== sv/hmh_ctrl.sv =====
module hmh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  hmh_pkg::hmh_flag_t flags,
  output hmh_pkg::hmh_cmd_t  cmd
);
  import hmh_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_LOOKUP   = 4'd2;
  localparam logic [3:0] S_POP_TAKE = 4'd3;
  localparam logic [3:0] S_AT_SLOT  = 4'd4;
  localparam logic [3:0] S_UP_ISSUE = 4'd5;
  localparam logic [3:0] S_UP_CMP   = 4'd6;
  localparam logic [3:0] S_DN_ISSUE = 4'd7;
  localparam logic [3:0] S_DN_CMP   = 4'd8;
  localparam logic [3:0] S_PLACE    = 4'd9;
  localparam logic [3:0] S_FINISH   = 4'd10;

  logic [3:0] state, state_next;
  logic       out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        case (flags.act)
          ACT_INSERT: begin
            if (flags.present) begin
              cmd.fail = 1'b1; cmd.fail_code = ST_DUP; state_next = S_FINISH;
            end else if (flags.full) begin
              cmd.fail = 1'b1; cmd.fail_code = ST_FULL; state_next = S_FINISH;
            end else begin
              cmd.ins_start = 1'b1; state_next = S_UP_ISSUE;
            end
          end
          ACT_POP: begin
            if (flags.empty) begin
              cmd.fail = 1'b1; cmd.fail_code = ST_EMPTY; state_next = S_FINISH;
            end else begin
              cmd.pop_start = 1'b1; state_next = S_POP_TAKE;
            end
          end
          default: begin
            if (!flags.present) begin
              cmd.fail = 1'b1; cmd.fail_code = ST_ABSENT; state_next = S_FINISH;
            end else begin
              state_next = S_LOOKUP;
            end
          end
        endcase
      end
      S_LOOKUP: begin
        cmd.locate = 1'b1;
        state_next = S_AT_SLOT;
      end
      S_POP_TAKE: begin
        cmd.pop_take = 1'b1;
        state_next   = S_DN_ISSUE;
      end
      S_AT_SLOT: begin
        cmd.at_slot = 1'b1;
        if (flags.act == ACT_DELETE && flags.last_slot) state_next = S_FINISH;
        else if (flags.grow)                             state_next = S_DN_ISSUE;
        else if (flags.shrink)                           state_next = S_UP_ISSUE;
        else                                             state_next = S_PLACE;
      end
      S_UP_ISSUE: begin
        cmd.up_issue = 1'b1;
        state_next   = flags.at_root ? S_PLACE : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (flags.up_swap) begin
          cmd.up_move = 1'b1; state_next = S_UP_ISSUE;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_DN_ISSUE: begin
        cmd.dn_issue = 1'b1;
        state_next   = flags.no_child ? S_PLACE : S_DN_CMP;
      end
      S_DN_CMP: begin
        if (flags.dn_swap) begin
          cmd.dn_move = 1'b1; state_next = S_DN_ISSUE;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.load_out | (out_valid & out_stall);
  assign in_stall       = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/hmh_dp.sv =====
module hmh_dp #(
  parameter int CAPACITY      = hmh_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = hmh_pkg::PRIO_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  action,
  input  logic [hmh_pkg::ID_BITS-1:0] entry_id,
  input  logic signed [31:0]          priority_req,
  input  hmh_pkg::hmh_cmd_t           cmd,
  output hmh_pkg::hmh_flag_t          flags,
  output logic [hmh_pkg::ID_BITS-1:0] popped_id,
  output logic [2:0]                  status,
  output logic [8:0]                  occupancy
);
  import hmh_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = SW + 1;
  localparam int PB = PRIORITY_BITS;

  // heap stores: key and owner per slot, two read ports, one write port
  logic [PB-1:0]      key_mem [CAPACITY];
  logic [ID_BITS-1:0] own_mem [CAPACITY];
  logic [SW-1:0]      soi_mem [ID_COUNT];

  logic [PB-1:0]      rda_key, rdb_key;
  logic [ID_BITS-1:0] rda_own, rdb_own;
  logic [SW-1:0]      soi_q;
  logic [SW-1:0]      rda_addr, rdb_addr;

  logic [1:0]          act_r;
  logic [ID_BITS-1:0]  id_r;
  logic [PB-1:0]       key_r;
  logic [ID_COUNT-1:0] present;
  logic [CW-1:0]       cnt;
  logic [SW-1:0]       slot;
  logic [PB-1:0]       cur_key;
  logic [ID_BITS-1:0]  cur_own;
  logic [ID_BITS-1:0]  popped_r;
  logic [2:0]          status_r;
  logic [ID_BITS-1:0]  out_popped;
  logic [2:0]          out_status;
  logic [CW-1:0]       out_cnt;

  logic [63:0]        prio_ext;
  logic [PB-1:0]      key_in;
  logic [CW-1:0]      cw, cw1, last;
  logic [SW-1:0]      parent;
  logic               pick_right;
  logic [PB-1:0]      child_key, new_key;
  logic [ID_BITS-1:0] child_own;
  logic [SW-1:0]      child_idx;
  logic               is_del;
  logic               mem_we;
  logic [PB-1:0]      wr_key;
  logic [ID_BITS-1:0] wr_own;
  logic [CW+8:0]      occ_w;

  // sign-extend, wrap to PB bits, flip the sign bit for unsigned ordering
  assign prio_ext = {{32{priority_req[31]}}, priority_req};
  assign key_in   = prio_ext[PB-1:0] ^ {1'b1, {(PB-1){1'b0}}};

  assign cw        = {slot, 1'b1};
  assign cw1       = cw + CW'(1);
  assign last      = cnt - CW'(1);
  assign parent    = (slot - SW'(1)) >> 1;
  assign is_del    = (act_r == ACT_DELETE);
  assign new_key   = is_del ? rdb_key : key_r;

  assign pick_right = (cw1 < cnt) && (rdb_key < rda_key);
  assign child_key  = pick_right ? rdb_key : rda_key;
  assign child_own  = pick_right ? rdb_own : rda_own;
  assign child_idx  = pick_right ? cw1[SW-1:0] : cw[SW-1:0];

  always_comb begin
    rda_addr = slot;
    rdb_addr = last[SW-1:0];
    if (cmd.pop_start) begin
      rda_addr = '0;
    end else if (cmd.locate) begin
      rda_addr = soi_q;
    end else if (cmd.up_issue) begin
      rda_addr = parent;
    end else if (cmd.dn_issue) begin
      rda_addr = cw[SW-1:0];
      rdb_addr = cw1[SW-1:0];
    end
  end

  always_comb begin
    mem_we = cmd.up_move | cmd.dn_move | cmd.place;
    wr_key = cur_key;
    wr_own = cur_own;
    if (cmd.up_move) begin
      wr_key = rda_key; wr_own = rda_own;
    end else if (cmd.dn_move) begin
      wr_key = child_key; wr_own = child_own;
    end
  end

  always_ff @(posedge clk) begin
    rda_key <= key_mem[rda_addr];
    rda_own <= own_mem[rda_addr];
    rdb_key <= key_mem[rdb_addr];
    rdb_own <= own_mem[rdb_addr];
    if (mem_we) begin
      key_mem[slot] <= wr_key;
      own_mem[slot] <= wr_own;
    end
  end

  always_ff @(posedge clk) begin
    soi_q <= soi_mem[id_r];
    if (mem_we) soi_mem[wr_own] <= slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      cnt     <= '0;
    end else begin
      if (cmd.ins_start) begin
        present[id_r] <= 1'b1;
        cnt           <= cnt + CW'(1);
      end
      if (cmd.pop_take) begin
        present[rda_own] <= 1'b0;
        cnt              <= last;
      end
      if (cmd.at_slot && is_del) begin
        present[id_r] <= 1'b0;
        cnt           <= last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r    <= action;
      id_r     <= entry_id;
      key_r    <= key_in;
      popped_r <= '0;
      status_r <= ST_OK;
    end
    if (cmd.fail) status_r <= cmd.fail_code;
    if (cmd.ins_start) begin
      slot    <= cnt[SW-1:0];
      cur_key <= key_r;
      cur_own <= id_r;
    end
    if (cmd.pop_take) begin
      popped_r <= rda_own;
      slot     <= '0;
      cur_key  <= rdb_key;
      cur_own  <= rdb_own;
    end
    if (cmd.locate) slot <= soi_q;
    if (cmd.at_slot) begin
      cur_key <= new_key;
      cur_own <= is_del ? rdb_own : id_r;
    end
    if (cmd.up_move) slot <= parent;
    if (cmd.dn_move) slot <= child_idx;
    if (cmd.load_out) begin
      out_popped <= popped_r;
      out_status <= status_r;
      out_cnt    <= cnt;
    end
  end

  assign flags.act       = act_r;
  assign flags.present   = present[id_r];
  assign flags.full      = (cnt == CW'(CAPACITY));
  assign flags.empty     = (cnt == '0);
  assign flags.last_slot = ({1'b0, slot} == last);
  assign flags.grow      = (rda_key < new_key);
  assign flags.shrink    = (rda_key > new_key);
  assign flags.at_root   = (slot == '0);
  assign flags.up_swap   = (cur_key < rda_key);
  assign flags.no_child  = (cw >= cnt);
  assign flags.dn_swap   = (cur_key > child_key);

  assign occ_w     = {9'b0, out_cnt};
  assign occupancy = occ_w[8:0];
  assign popped_id = out_popped;
  assign status    = out_status;

endmodule

// ===== sv/indexed_min_heap_core.sv =====
// Flow: a rejected request goes from the check straight to the result; an
//   accepted one may also fetch, sift the hole up or down and place an entry.
// Throughput: one request at a time; the next is taken once the current one
//   has loaded the output register. Sift length, set by the shared heap RAM
//   (two reads, one write per cycle), sets the rate.
// Reset: clears the entry count, all presence flags and the output valid.
module indexed_min_heap_core #(
  parameter int CAPACITY      = hmh_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = hmh_pkg::PRIO_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic [hmh_pkg::ID_BITS-1:0] entry_id,
  input  logic signed [31:0]          priority_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hmh_pkg::ID_BITS-1:0] popped_id,
  output logic [2:0]                  status,
  output logic [8:0]                  occupancy
);
  import hmh_pkg::*;

  hmh_cmd_t  cmd;
  hmh_flag_t flags;

  // Sequencer: check, fetch, then hole-based sift up or down
  hmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  // Heap RAM, id->slot RAM, presence flags, count and result register
  hmh_dp #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .action       (action),
    .entry_id     (entry_id),
    .priority_req (priority_req),
    .cmd          (cmd),
    .flags        (flags),
    .popped_id    (popped_id),
    .status       (status),
    .occupancy    (occupancy)
  );

  // an accepted request blocks the input until it finishes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // a failed request never reports a popped id
  a_fail_no_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (popped_id == '0))
    else $error("popped id on failed request");

  // a new result only appears while a request was in progress
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without request");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import hmh_pkg::*;

  localparam int HEAP_CAP = CAPACITY_DEF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_POP;
  logic [7:0]  entry_id = '0;
  logic signed [31:0] priority_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  popped_id;
  logic [2:0]  status;
  logic [8:0]  occupancy;

  indexed_min_heap_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .entry_id(entry_id), .priority_req(priority_req),
    .out_valid(out_valid), .out_stall(out_stall),
    .popped_id(popped_id), .status(status), .occupancy(occupancy)
  );

  always #2 clk = ~clk;

  // expected response fields
  typedef struct packed {
    logic [7:0] popped;
    logic [2:0] stat;
    logic [8:0] occ;
  } heap_resp_t;

  heap_resp_t resp_q[$];
  int  errors = 0;

  // knobs for the sender and the receiver
  bit  idle_on = 1'b1;       // random bursts of idling on both sides
  bit  long_hold = 1'b0;     // asks the receiver for a long hold-off
  int  hold_cycles = 0;      // receiver hold-off countdown

  // shadow heap: priorities kept as signed 32-bit, so compare directly
  logic signed [31:0] hp_prio [HEAP_CAP];
  logic [7:0]         hp_owner[HEAP_CAP];
  int                 id_slot [256];
  bit                 id_in   [256];
  int                 hp_count;

  function automatic void hp_swap(int a, int b);
    logic signed [31:0] p;
    logic [7:0] o;
    p = hp_prio[a]; hp_prio[a] = hp_prio[b]; hp_prio[b] = p;
    o = hp_owner[a]; hp_owner[a] = hp_owner[b]; hp_owner[b] = o;
    id_slot[hp_owner[a]] = a;
    id_slot[hp_owner[b]] = b;
  endfunction

  function automatic void hp_rise(int s);
    int p;
    while (s > 0) begin
      p = (s - 1) / 2;
      if (hp_prio[s] >= hp_prio[p]) break;
      hp_swap(s, p);
      s = p;
    end
  endfunction

  function automatic void hp_sink(int s);
    int c;
    forever begin
      c = 2 * s + 1;
      if (c >= hp_count) break;
      // left child wins a tie
      if (c + 1 < hp_count && hp_prio[c + 1] < hp_prio[c]) c++;
      if (hp_prio[s] <= hp_prio[c]) break;
      hp_swap(s, c);
      s = c;
    end
  endfunction

  function automatic void hp_rekey(int s, logic signed [31:0] k);
    logic signed [31:0] old;
    old = hp_prio[s];
    hp_prio[s] = k;
    if (old < k) hp_sink(s);
    else if (old > k) hp_rise(s);
  endfunction

  // applies one request to the shadow heap, returns the response it owes
  function automatic heap_resp_t heap_apply(logic [1:0] act, logic [7:0] id,
                                            logic signed [31:0] pr);
    heap_resp_t r;
    int s, last;
    r.popped = '0;
    r.stat   = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (id_in[id]) r.stat = ST_DUP;          // dup check beats full check
        else if (hp_count >= HEAP_CAP) r.stat = ST_FULL;
        else begin
          s = hp_count;
          hp_prio[s] = pr; hp_owner[s] = id; id_slot[id] = s; id_in[id] = 1'b1;
          hp_count++;
          hp_rise(s);
        end
      end
      ACT_POP: begin
        if (hp_count == 0) r.stat = ST_EMPTY;
        else begin
          r.popped = hp_owner[0];
          id_in[r.popped] = 1'b0;
          hp_count--;
          hp_prio[0] = hp_prio[hp_count];
          hp_owner[0] = hp_owner[hp_count];
          id_slot[hp_owner[0]] = 0;
          hp_sink(0);
        end
      end
      default: begin
        if (!id_in[id]) r.stat = ST_ABSENT;
        else if (act == ACT_DELETE) begin
          s = id_slot[id];
          id_in[id] = 1'b0;
          hp_count--;
          last = hp_count;
          if (s != last) begin
            hp_owner[s] = hp_owner[last];
            id_slot[hp_owner[last]] = s;
            hp_rekey(s, hp_prio[last]);
          end
        end else hp_rekey(id_slot[id], pr);
      end
    endcase
    r.occ = hp_count[8:0];
    return r;
  endfunction

  // sender: one request, optional idle burst first; valid stays up after
  // the accept until the next request or an idle burst replaces it
  task automatic send_req(logic [1:0] act, logic [7:0] id, logic signed [31:0] pr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    entry_id     <= id;
    priority_req <= pr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    resp_q.push_back(heap_apply(act, id, pr));
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (long_hold) begin
      long_hold = 1'b0;
      out_stall   <= 1'b1;
      hold_cycles <= 300;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_on && !out_stall && $urandom_range(0, 5) == 0)
      hold_cycles <= $urandom_range(1, 17);
    else out_stall <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    heap_resp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (resp_q.size() == 0) begin
        $error("unexpected response: popped_id %0d status %0d occupancy %0d",
               popped_id, status, occupancy);
        errors++;
      end else begin
        e = resp_q.pop_front();
        if (popped_id !== e.popped) begin
          $error("popped_id expected %0d actual %0d", e.popped, popped_id);
          errors++;
        end
        if (status !== e.stat) begin
          $error("status expected %0d actual %0d", e.stat, status);
          errors++;
        end
        if (occupancy !== e.occ) begin
          $error("occupancy expected %0d actual %0d", e.occ, occupancy);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_prio();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 15)) - 8;   // many ties
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  // wait until every response is back
  task automatic drain();
    in_valid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
  endtask

  // error paths, ties, rekeys and deletes with corner priorities
  task automatic test_directed();
    send_req(ACT_POP, 8'd0, 0);                     // pop on empty
    send_req(ACT_DELETE, 8'd255, 0);                // delete absent id
    send_req(ACT_CHANGE, 8'd0, 5);                  // change absent id
    send_req(ACT_INSERT, 8'd0, 32'sh7fffffff);
    send_req(ACT_INSERT, 8'd255, 32'sh80000000);
    send_req(ACT_INSERT, 8'd0, 1);                  // duplicate insert
    send_req(ACT_INSERT, 8'd170, 0);
    send_req(ACT_INSERT, 8'd85, 0);                 // equal priority tie
    send_req(ACT_INSERT, 8'd3, -1);
    send_req(ACT_CHANGE, 8'd3, -1);                 // same priority
    send_req(ACT_CHANGE, 8'd255, 32'sh7fffffff);    // grow: sinks
    send_req(ACT_CHANGE, 8'd0, 32'sh80000000);      // shrink: rises
    send_req(ACT_DELETE, 8'd170, 0);
    send_req(ACT_DELETE, 8'd255, 0);                // delete, last entry fills the hole
    repeat (5) send_req(ACT_POP, 8'd0, 0);          // drain then empty again
  endtask

  // fill to capacity, try a duplicate, then pop part of it back out
  task automatic test_full();
    for (int i = 0; i < HEAP_CAP; i++) send_req(ACT_INSERT, i[7:0], rand_prio());
    send_req(ACT_INSERT, 8'd7, 0);                  // present id: dup, not full
    for (int i = 0; i < HEAP_CAP; i++)
      if (!id_in[i]) send_req(ACT_INSERT, i[7:0], 0);
    // full heap: all ids present, so full is unreachable with unique ids;
    // rest keeps the heap deep for later random traffic
    for (int i = 0; i < 40; i++) send_req(ACT_POP, 8'd0, 0);
  endtask

  // mixed random traffic, biased toward valid ids
  task automatic test_random(int n);
    logic [1:0] act;
    logic [7:0] id;
    for (int i = 0; i < n; i++) begin
      act = 2'($urandom_range(0, 3));
      id  = 8'($urandom);
      if (act != ACT_INSERT && $urandom_range(0, 4) != 0 && hp_count > 0)
        id = hp_owner[$urandom_range(0, hp_count - 1)];
      send_req(act, id, rand_prio());
    end
  endtask

  // receiver holds off long while requests keep coming
  task automatic test_backpressure();
    long_hold = 1'b1;
    test_random(30);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    hp_count = 0;
    test_directed();
    test_full();
    test_backpressure();
    test_random(70);
    idle_on = 1'b0;             // last stretch at full rate
    test_random(40);
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && resp_q.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
sv/hmh_pkg.sv
sv/hmh_ctrl.sv
sv/hmh_dp.sv
sv/indexed_min_heap_core.sv
sim/tb_top.sv
